>>> rtl/leps_pkg.sv
// Shared types and constants for the lane-edge perspective slope block.
// Holds field widths, homography coefficients, register indexes and stage payload structs.
// No dependencies.
package leps_pkg;

   localparam int ROW_W       = 7;
   localparam int COL_IN_W    = 16;
   localparam int COL_W       = 8;
   localparam int WHEEL_W     = 8;
   localparam int GX_W        = 11;
   localparam int GY_W        = 8;
   localparam int SLOPE_W     = 19;

   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 96;
   localparam int RSP_USER_W  = 2;
   localparam int CSR_INDEX_W = 2;

   localparam int NX_W        = 30;
   localparam int MAP_NUM_W   = 28;
   localparam int MAP_DEN_W   = 20;
   localparam int MAP_Q       = 12;
   localparam int MAP_CMP_W   = MAP_DEN_W + MAP_Q;
   localparam int MAP_LANES   = 3;

   localparam int DIFF_W      = 12;
   localparam int ABSD_W      = 11;
   localparam int SLOPE_NUM_W = 18;
   localparam int SLOPE_DEN_W = 8;
   localparam int SLOPE_Q     = 18;
   localparam int SLOPE_LANES = 2;

   localparam int LANE_L = 0;
   localparam int LANE_R = 1;
   localparam int LANE_Y = 2;

   localparam logic signed [NX_W-1:0] K_A1  = 30'sd457143;
   localparam logic signed [NX_W-1:0] K_B1  = -30'sd801429;
   localparam logic signed [NX_W-1:0] K_C1  = 30'sd50757143;
   localparam logic signed [NX_W-1:0] K_B2  = 30'sd331429;
   localparam logic signed [NX_W-1:0] K_C2  = 30'sd4914286;
   localparam logic signed [NX_W-1:0] K_B3  = -30'sd8571;
   localparam logic signed [NX_W-1:0] K_ONE = 30'sd1000000;

   localparam logic [SLOPE_NUM_W-1:0] SLOPE_GAIN = 18'd125;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_WHEEL_X    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_WHEEL_X   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_FORWARD_Y = 2'd2;

   localparam logic [WHEEL_W-1:0] LEFT_WHEEL_X_RST    = 8'd67;
   localparam logic [WHEEL_W-1:0] RIGHT_WHEEL_X_RST   = 8'd97;
   localparam logic [WHEEL_W-1:0] WHEEL_FORWARD_Y_RST = 8'd0;

   typedef struct packed {
      logic [COL_W-1:0]     col_l;
      logic [COL_W-1:0]     col_r;
      logic                 in_table;
      logic [MAP_LANES-1:0] neg;
      logic [MAP_LANES-1:0] ovf;
   } map_pass_type;

   typedef struct packed {
      logic [COL_W-1:0]       col_l;
      logic [COL_W-1:0]       col_r;
      logic signed [GX_W-1:0] gx_l;
      logic signed [GX_W-1:0] gx_r;
      logic [GY_W-1:0]        gy;
      logic [SLOPE_LANES-1:0] neg;
      logic                   dz;
   } slope_pass_type;

endpackage

>>> rtl/lane_edge_perspective_slope.sv
// Lane-edge perspective slope: clamps both edge columns, maps them to ground coordinates
// and forms 125*dx/dy against the wheel reference points.
// Uses leps_pkg and leps_div_chain (two chains of leps_div_cell).
//
// One edge pair is taken per clock cycle and one result leaves per cycle when the
// sink keeps up. A req transaction passes on its way to rsp_tvalid through three
// front stages (clamp, numerator products, magnitudes), twelve mapping cells, two
// saturation/slope-setup stages, eighteen slope cells and the output register. The two
// divider cell rows hold most of these stages, each cell resolving one quotient bit for
// every lane. Every stage holds its own valid bit, so bubbles close up under
// backpressure. Register writes on the csr port take effect at once and are meant
// for times when no transaction is in flight; index 3 is ignored.
module lane_edge_perspective_slope #(
   parameter int TABLE_ROWS  = 80,
   parameter int IMAGE_WIDTH = 188
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // row[6:0], left_col[22:7], right_col[38:23], zero pad [39]
   input  logic [leps_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // left_clamped[7:0], right_clamped[15:8], left_ground_x[26:16], left_ground_y[34:27],
   // right_ground_x[45:35], right_ground_y[53:46], left_slope[72:54],
   // right_slope[91:73], zero pad [95:92]
   output logic [leps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // left_div_zero[0], right_div_zero[1]
   output logic [leps_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [leps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [leps_pkg::WHEEL_W-1:0]         csr_data
);

   localparam int ROW_W       = leps_pkg::ROW_W;
   localparam int COL_IN_W    = leps_pkg::COL_IN_W;
   localparam int COL_W       = leps_pkg::COL_W;
   localparam int WHEEL_W     = leps_pkg::WHEEL_W;
   localparam int GX_W        = leps_pkg::GX_W;
   localparam int GY_W        = leps_pkg::GY_W;
   localparam int SLOPE_W     = leps_pkg::SLOPE_W;
   localparam int NX_W        = leps_pkg::NX_W;
   localparam int MAP_NUM_W   = leps_pkg::MAP_NUM_W;
   localparam int MAP_DEN_W   = leps_pkg::MAP_DEN_W;
   localparam int MAP_Q       = leps_pkg::MAP_Q;
   localparam int MAP_CMP_W   = leps_pkg::MAP_CMP_W;
   localparam int MAP_LANES   = leps_pkg::MAP_LANES;
   localparam int DIFF_W      = leps_pkg::DIFF_W;
   localparam int ABSD_W      = leps_pkg::ABSD_W;
   localparam int SLOPE_NUM_W = leps_pkg::SLOPE_NUM_W;
   localparam int SLOPE_DEN_W = leps_pkg::SLOPE_DEN_W;
   localparam int SLOPE_Q     = leps_pkg::SLOPE_Q;
   localparam int SLOPE_LANES = leps_pkg::SLOPE_LANES;
   localparam int LANE_L      = leps_pkg::LANE_L;
   localparam int LANE_R      = leps_pkg::LANE_R;
   localparam int LANE_Y      = leps_pkg::LANE_Y;
   localparam int MAP_PASS_W   = $bits(leps_pkg::map_pass_type);
   localparam int SLOPE_PASS_W = $bits(leps_pkg::slope_pass_type);

   localparam logic [COL_IN_W-1:0] COL_LAST   = COL_IN_W'(IMAGE_WIDTH - 1);
   localparam logic [ROW_W-1:0]    ROW_LIMIT  = ROW_W'(TABLE_ROWS);
   localparam logic [MAP_Q-1:0]    GX_POS_MAX = MAP_Q'(2 ** (GX_W - 1) - 1);
   localparam logic [MAP_Q-1:0]    GY_MAX     = MAP_Q'(2 ** GY_W - 1);

   function automatic logic [COL_W-1:0] clamp_col(input logic [COL_IN_W-1:0] c);
      logic [COL_W-1:0] res;
      if (c[COL_IN_W-1]) begin
         res = '0;
      end else if (c > COL_LAST) begin
         res = COL_LAST[COL_W-1:0];
      end else begin
         res = c[COL_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [GX_W-1:0] sat_gx(input logic neg, input logic ovf,
                                              input logic [MAP_Q-1:0] q);
      logic [GX_W-1:0] res;
      if (neg) begin
         if (ovf || q > GX_POS_MAX) begin
            res = {1'b1, {(GX_W-1){1'b0}}};
         end else begin
            res = -q[GX_W-1:0];
         end
      end else if (ovf || q > GX_POS_MAX) begin
         res = {1'b0, {(GX_W-1){1'b1}}};
      end else begin
         res = q[GX_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [GY_W-1:0] sat_gy(input logic neg, input logic ovf,
                                              input logic [MAP_Q-1:0] q);
      logic [GY_W-1:0] res;
      if (neg) begin
         res = '0;
      end else if (ovf || q > GY_MAX) begin
         res = '1;
      end else begin
         res = q[GY_W-1:0];
      end
      return res;
   endfunction

   // ---------------- configuration registers
   logic [WHEEL_W-1:0] left_wheel_x_ff, right_wheel_x_ff, wheel_forward_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_wheel_x_ff    <= leps_pkg::LEFT_WHEEL_X_RST;
         right_wheel_x_ff   <= leps_pkg::RIGHT_WHEEL_X_RST;
         wheel_forward_y_ff <= leps_pkg::WHEEL_FORWARD_Y_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            leps_pkg::CSR_LEFT_WHEEL_X:    left_wheel_x_ff    <= csr_data;
            leps_pkg::CSR_RIGHT_WHEEL_X:   right_wheel_x_ff   <= csr_data;
            leps_pkg::CSR_WHEEL_FORWARD_Y: wheel_forward_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: clamp
   logic             s1_valid_ff, s1_ready;
   logic [COL_W-1:0] s1_col_l_ff, s1_col_r_ff, s1_col_l_in, s1_col_r_in;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_in_table_ff, s1_in_table_in;
   logic             s2_ready;

   assign s1_col_l_in    = clamp_col(req_tdata[22:7]);
   assign s1_col_r_in    = clamp_col(req_tdata[38:23]);
   assign s1_in_table_in = req_tdata[6:0] < ROW_LIMIT;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_tready     = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && s1_ready) begin
         s1_col_l_ff    <= s1_col_l_in;
         s1_col_r_ff    <= s1_col_r_in;
         s1_row_ff      <= req_tdata[6:0];
         s1_in_table_ff <= s1_in_table_in;
      end
   end

   // ---------------- stage 2: homography numerators and denominator
   logic                   s2_valid_ff;
   logic signed [NX_W-1:0] s2_num_ff [MAP_LANES];
   logic signed [NX_W-1:0] s2_num_in [MAP_LANES];
   logic signed [NX_W-1:0] s2_den_ff, s2_den_in;
   logic signed [NX_W-1:0] row_x, col_l_x, col_r_x, row_term;
   logic [COL_W-1:0]       s2_col_l_ff, s2_col_r_ff;
   logic                   s2_in_table_ff;
   logic                   s3_ready;

   assign row_x    = NX_W'(s1_row_ff);
   assign col_l_x  = NX_W'(s1_col_l_ff);
   assign col_r_x  = NX_W'(s1_col_r_ff);
   assign row_term = leps_pkg::K_B1 * row_x + leps_pkg::K_C1;

   assign s2_num_in[LANE_L] = leps_pkg::K_A1 * col_l_x + row_term;
   assign s2_num_in[LANE_R] = leps_pkg::K_A1 * col_r_x + row_term;
   assign s2_num_in[LANE_Y] = leps_pkg::K_B2 * row_x + leps_pkg::K_C2;
   assign s2_den_in         = leps_pkg::K_B3 * row_x + leps_pkg::K_ONE;
   assign s2_ready          = !s2_valid_ff || s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_num_ff      <= s2_num_in;
         s2_den_ff      <= s2_den_in;
         s2_col_l_ff    <= s1_col_l_ff;
         s2_col_r_ff    <= s1_col_r_ff;
         s2_in_table_ff <= s1_in_table_ff;
      end
   end

   // ---------------- stage 3: magnitudes, quotient signs, overflow check
   logic                                s3_valid_ff;
   logic [MAP_LANES-1:0][MAP_NUM_W-1:0] s3_rem_ff, s3_rem_in;
   logic [MAP_DEN_W-1:0]                s3_den_ff, s3_den_in;
   leps_pkg::map_pass_type              s3_pass_ff, s3_pass_in;
   logic [NX_W-1:0]                     den_abs;
   logic [NX_W-1:0]                     num_abs [MAP_LANES];
   logic                                map_in_ready;

   always_comb begin
      den_abs   = s2_den_ff[NX_W-1] ? NX_W'(-s2_den_ff) : NX_W'(s2_den_ff);
      s3_den_in = den_abs[MAP_DEN_W-1:0];
      s3_pass_in.col_l    = s2_col_l_ff;
      s3_pass_in.col_r    = s2_col_r_ff;
      s3_pass_in.in_table = s2_in_table_ff;
      for (int i = 0; i < MAP_LANES; i++) begin
         num_abs[i]   = s2_num_ff[i][NX_W-1] ? NX_W'(-s2_num_ff[i]) : NX_W'(s2_num_ff[i]);
         s3_rem_in[i] = num_abs[i][MAP_NUM_W-1:0];
         s3_pass_in.neg[i] = s2_num_ff[i][NX_W-1] ^ s2_den_ff[NX_W-1];
         s3_pass_in.ovf[i] = MAP_CMP_W'(s3_rem_in[i]) >= (MAP_CMP_W'(s3_den_in) << MAP_Q);
      end
   end

   assign s3_ready = !s3_valid_ff || map_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_ready) begin
         s3_rem_ff  <= s3_rem_in;
         s3_den_ff  <= s3_den_in;
         s3_pass_ff <= s3_pass_in;
      end
   end

   // ---------------- mapping divider
   logic                            map_out_valid, s4_ready;
   logic [MAP_LANES-1:0][MAP_Q-1:0] map_out_quot;
   leps_pkg::map_pass_type          map_out_pass;

   leps_div_chain #(
      .LANES(MAP_LANES), .NUM_W(MAP_NUM_W), .DEN_W(MAP_DEN_W), .QUOT_W(MAP_Q),
      .PASS_W(MAP_PASS_W)
   ) u_map_div (
      .clock(clock), .reset(reset),
      .in_valid(s3_valid_ff), .in_ready(map_in_ready),
      .in_rem(s3_rem_ff), .in_den(s3_den_ff), .in_pass(s3_pass_ff),
      .out_valid(map_out_valid), .out_ready(s4_ready),
      .out_quot(map_out_quot), .out_pass(map_out_pass)
   );

   // ---------------- stage 4: saturate, zero the results of rows beyond the table
   logic                   s4_valid_ff;
   logic signed [GX_W-1:0] s4_gx_l_ff, s4_gx_r_ff, s4_gx_l_in, s4_gx_r_in;
   logic [GY_W-1:0]        s4_gy_ff, s4_gy_in;
   logic [COL_W-1:0]       s4_col_l_ff, s4_col_r_ff;
   logic                   s5_ready;

   always_comb begin
      if (map_out_pass.in_table) begin
         s4_gx_l_in = sat_gx(map_out_pass.neg[LANE_L], map_out_pass.ovf[LANE_L],
                             map_out_quot[LANE_L]);
         s4_gx_r_in = sat_gx(map_out_pass.neg[LANE_R], map_out_pass.ovf[LANE_R],
                             map_out_quot[LANE_R]);
         s4_gy_in   = sat_gy(map_out_pass.neg[LANE_Y], map_out_pass.ovf[LANE_Y],
                             map_out_quot[LANE_Y]);
      end else begin
         s4_gx_l_in = '0;
         s4_gx_r_in = '0;
         s4_gy_in   = '0;
      end
   end

   assign s4_ready = !s4_valid_ff || s5_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= map_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (map_out_valid && s4_ready) begin
         s4_gx_l_ff  <= s4_gx_l_in;
         s4_gx_r_ff  <= s4_gx_r_in;
         s4_gy_ff    <= s4_gy_in;
         s4_col_l_ff <= map_out_pass.col_l;
         s4_col_r_ff <= map_out_pass.col_r;
      end
   end

   // ---------------- stage 5: slope numerator and divisor magnitudes
   logic                                    s5_valid_ff;
   logic [SLOPE_LANES-1:0][SLOPE_NUM_W-1:0] s5_rem_ff, s5_rem_in;
   logic [SLOPE_DEN_W-1:0]                  s5_den_ff, s5_den_in;
   leps_pkg::slope_pass_type                s5_pass_ff, s5_pass_in;
   logic [DIFF_W-1:0]                       diff_l, diff_r, absd_l, absd_r;
   logic [GY_W:0]                           dy, dy_abs;
   logic                                    slope_in_ready;

   always_comb begin
      diff_l = {{(DIFF_W-GX_W){s4_gx_l_ff[GX_W-1]}}, s4_gx_l_ff}
             - {{(DIFF_W-WHEEL_W){1'b0}}, left_wheel_x_ff};
      diff_r = {{(DIFF_W-GX_W){s4_gx_r_ff[GX_W-1]}}, s4_gx_r_ff}
             - {{(DIFF_W-WHEEL_W){1'b0}}, right_wheel_x_ff};
      absd_l = diff_l[DIFF_W-1] ? -diff_l : diff_l;
      absd_r = diff_r[DIFF_W-1] ? -diff_r : diff_r;
      dy     = {1'b0, s4_gy_ff} - {1'b0, wheel_forward_y_ff};
      dy_abs = dy[GY_W] ? -dy : dy;

      s5_rem_in[LANE_L] = SLOPE_NUM_W'(absd_l[ABSD_W-1:0]) * leps_pkg::SLOPE_GAIN;
      s5_rem_in[LANE_R] = SLOPE_NUM_W'(absd_r[ABSD_W-1:0]) * leps_pkg::SLOPE_GAIN;
      s5_den_in         = dy_abs[SLOPE_DEN_W-1:0];

      s5_pass_in.col_l       = s4_col_l_ff;
      s5_pass_in.col_r       = s4_col_r_ff;
      s5_pass_in.gx_l        = s4_gx_l_ff;
      s5_pass_in.gx_r        = s4_gx_r_ff;
      s5_pass_in.gy          = s4_gy_ff;
      s5_pass_in.neg[LANE_L] = diff_l[DIFF_W-1] ^ dy[GY_W];
      s5_pass_in.neg[LANE_R] = diff_r[DIFF_W-1] ^ dy[GY_W];
      s5_pass_in.dz          = (dy == '0);
   end

   assign s5_ready = !s5_valid_ff || slope_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (s5_ready) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_valid_ff && s5_ready) begin
         s5_rem_ff  <= s5_rem_in;
         s5_den_ff  <= s5_den_in;
         s5_pass_ff <= s5_pass_in;
      end
   end

   // ---------------- slope divider
   logic                                slope_out_valid, out_ready;
   logic [SLOPE_LANES-1:0][SLOPE_Q-1:0] slope_out_quot;
   leps_pkg::slope_pass_type            slope_out_pass;

   leps_div_chain #(
      .LANES(SLOPE_LANES), .NUM_W(SLOPE_NUM_W), .DEN_W(SLOPE_DEN_W), .QUOT_W(SLOPE_Q),
      .PASS_W(SLOPE_PASS_W)
   ) u_slope_div (
      .clock(clock), .reset(reset),
      .in_valid(s5_valid_ff), .in_ready(slope_in_ready),
      .in_rem(s5_rem_ff), .in_den(s5_den_ff), .in_pass(s5_pass_ff),
      .out_valid(slope_out_valid), .out_ready(out_ready),
      .out_quot(slope_out_quot), .out_pass(slope_out_pass)
   );

   // ---------------- output register
   logic                       rsp_valid_ff;
   logic [SLOPE_W-1:0]         slope_l_ff, slope_r_ff, slope_l_in, slope_r_in;
   leps_pkg::slope_pass_type   out_pass_ff;

   always_comb begin
      if (slope_out_pass.dz) begin
         slope_l_in = '0;
         slope_r_in = '0;
      end else begin
         slope_l_in = slope_out_pass.neg[LANE_L] ? -SLOPE_W'(slope_out_quot[LANE_L])
                                                 : SLOPE_W'(slope_out_quot[LANE_L]);
         slope_r_in = slope_out_pass.neg[LANE_R] ? -SLOPE_W'(slope_out_quot[LANE_R])
                                                 : SLOPE_W'(slope_out_quot[LANE_R]);
      end
   end

   assign out_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= slope_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (slope_out_valid && out_ready) begin
         slope_l_ff  <= slope_l_in;
         slope_r_ff  <= slope_r_in;
         out_pass_ff <= slope_out_pass;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, slope_r_ff, slope_l_ff,
                        out_pass_ff.gy, out_pass_ff.gx_r,
                        out_pass_ff.gy, out_pass_ff.gx_l,
                        out_pass_ff.col_r, out_pass_ff.col_l};
   assign rsp_tuser  = {out_pass_ff.dz, out_pass_ff.dz};

endmodule

>>> rtl/leps_div_cell.sv
// One restoring-division step: tests and subtracts the shifted divisor on every lane.
// Registered stage with its own valid/ready; carries divisor and side payload along.
// No package dependency.
module leps_div_cell #(
   parameter int LANES  = 3,
   parameter int NUM_W  = 28,
   parameter int DEN_W  = 20,
   parameter int QUOT_W = 12,
   parameter int SHIFT  = 11,
   parameter int PASS_W = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [LANES-1:0][NUM_W-1:0]   in_rem,
   input  logic [LANES-1:0][QUOT_W-1:0]  in_quot,
   input  logic [DEN_W-1:0]              in_den,
   input  logic [PASS_W-1:0]             in_pass,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [LANES-1:0][NUM_W-1:0]   out_rem,
   output logic [LANES-1:0][QUOT_W-1:0]  out_quot,
   output logic [DEN_W-1:0]              out_den,
   output logic [PASS_W-1:0]             out_pass
);

   localparam int CMP_W = DEN_W + QUOT_W;

   logic                         valid_ff;
   logic [LANES-1:0][NUM_W-1:0]  rem_ff, rem_in;
   logic [LANES-1:0][QUOT_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0]             den_ff;
   logic [PASS_W-1:0]            pass_ff;
   logic [CMP_W-1:0]             den_shift;

   assign den_shift = CMP_W'(in_den) << SHIFT;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         quot_in[i] = in_quot[i];
         if (CMP_W'(in_rem[i]) >= den_shift) begin
            rem_in[i]         = NUM_W'(CMP_W'(in_rem[i]) - den_shift);
            quot_in[i][SHIFT] = 1'b1;
         end else begin
            rem_in[i]         = in_rem[i];
            quot_in[i][SHIFT] = 1'b0;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         den_ff  <= in_den;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quot  = quot_ff;
   assign out_den   = den_ff;
   assign out_pass  = pass_ff;

endmodule

>>> rtl/leps_div_chain.sv
// Row of division cells, one quotient bit per cell from the top bit down.
// Uses leps_div_cell; divisor is shared by all lanes of one transaction.
module leps_div_chain #(
   parameter int LANES  = 3,
   parameter int NUM_W  = 28,
   parameter int DEN_W  = 20,
   parameter int QUOT_W = 12,
   parameter int PASS_W = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [LANES-1:0][NUM_W-1:0]   in_rem,
   input  logic [DEN_W-1:0]              in_den,
   input  logic [PASS_W-1:0]             in_pass,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [LANES-1:0][QUOT_W-1:0]  out_quot,
   output logic [PASS_W-1:0]             out_pass
);

   logic                         valid_c [QUOT_W+1];
   logic                         ready_c [QUOT_W+1];
   logic [LANES-1:0][NUM_W-1:0]  rem_c   [QUOT_W];
   logic [LANES-1:0][QUOT_W-1:0] quot_c  [QUOT_W+1];
   logic [DEN_W-1:0]             den_c   [QUOT_W];
   logic [PASS_W-1:0]            pass_c  [QUOT_W+1];

   assign valid_c[0] = in_valid;
   assign in_ready   = ready_c[0];
   assign rem_c[0]   = in_rem;
   assign quot_c[0]  = '0;
   assign den_c[0]   = in_den;
   assign pass_c[0]  = in_pass;

   for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
      if (k < QUOT_W - 1) begin : g_mid
         leps_div_cell #(
            .LANES(LANES), .NUM_W(NUM_W), .DEN_W(DEN_W), .QUOT_W(QUOT_W),
            .SHIFT(QUOT_W - 1 - k), .PASS_W(PASS_W)
         ) u_cell (
            .clock(clock), .reset(reset),
            .in_valid(valid_c[k]), .in_ready(ready_c[k]),
            .in_rem(rem_c[k]), .in_quot(quot_c[k]), .in_den(den_c[k]), .in_pass(pass_c[k]),
            .out_valid(valid_c[k+1]), .out_ready(ready_c[k+1]),
            .out_rem(rem_c[k+1]), .out_quot(quot_c[k+1]), .out_den(den_c[k+1]),
            .out_pass(pass_c[k+1])
         );
      end else begin : g_last
         leps_div_cell #(
            .LANES(LANES), .NUM_W(NUM_W), .DEN_W(DEN_W), .QUOT_W(QUOT_W),
            .SHIFT(QUOT_W - 1 - k), .PASS_W(PASS_W)
         ) u_cell (
            .clock(clock), .reset(reset),
            .in_valid(valid_c[k]), .in_ready(ready_c[k]),
            .in_rem(rem_c[k]), .in_quot(quot_c[k]), .in_den(den_c[k]), .in_pass(pass_c[k]),
            .out_valid(valid_c[k+1]), .out_ready(ready_c[k+1]),
            .out_rem(), .out_quot(quot_c[k+1]), .out_den(),
            .out_pass(pass_c[k+1])
         );
      end
   end

   assign out_valid       = valid_c[QUOT_W];
   assign ready_c[QUOT_W] = out_ready;
   assign out_quot        = quot_c[QUOT_W];
   assign out_pass        = pass_c[QUOT_W];

endmodule
